### hdl/cfrh_pkg.sv
// Package for the card frame receiver with hold timer.
// Holds operation codes, frame constants, register indexes and the result record type.
// No dependencies.
`default_nettype none

package cfrh_pkg;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    localparam logic CFG_HOLD = 1'b0;
    localparam logic CFG_BEEP = 1'b1;

    localparam int BUFFER_BYTES_DEF = 32;
    localparam int KEEP_BYTES       = 10;
    localparam int KEEP_IDX_W       = 4;
    localparam int CMP_W            = 9;
    localparam int WORDS            = 4;

    localparam logic [7:0]  FRAME_HEAD = 8'h02;
    localparam logic [7:0]  FRAME_TAIL = 8'h03;
    localparam logic [7:0]  MIN_LEN    = 8'd4;
    localparam logic [15:0] HOLD_RESET = 16'd3000;
    localparam logic [15:0] BEEP_RESET = 16'd500;

    localparam logic [7:0] TYPE_LOW    = 8'h02;
    localparam logic [7:0] TYPE_HIGH_A = 8'h01;
    localparam logic [7:0] TYPE_HIGH_B = 8'h03;

    localparam logic [15:0] TAG_ONE = 16'h0001;
    localparam logic [15:0] TAG_TWO = 16'h0002;

    localparam logic [4:0] LOW_BASE  = 5'd10;
    localparam logic [4:0] HIGH_BASE = 5'd14;
    localparam logic [4:0] HIGH_END  = 5'd18;

    typedef struct packed {
        logic [15:0] read_data;
        logic        frame_accepted;
        logic [7:0]  card_type;
        logic        data_cleared;
        logic        led_one;
        logic        led_two;
        logic        beep_on;
    } result_t;

    function automatic logic is_common_type(input logic [7:0] t);
        logic hit;
        begin
            case (t)
                8'h10, 8'h11, 8'h20, 8'h21, 8'h22, 8'h30, 8'h50, 8'h51, 8'hFF: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/card_frame_receiver_with_hold.sv
// Top level of the card frame receiver with hold timer.
// Depends on cfrh_pkg for codes, constants and the result record.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+----------------------------------------------
//  input    | in_valid / in_ready        | op, rx_byte, read_index
//  result   | out_valid / out_ready      | read_data, frame_accepted, card_type,
//           |                            | data_cleared, led_one, led_two, beep_on
//  config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// Each transaction is handled in a single pass: the frame check, decode, timers and word read all
// settle between the state registers and the result register, so one input is taken per cycle
// while in_ready is high. An accepted input's result is registered into the output buffer.
// A two-entry output buffer lets one more input be taken while the output is stalled;
// in_ready drops only when both entries are full. Reset is immediate, with no clearing pass.
`default_nettype none

module card_frame_receiver_with_hold
    import cfrh_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [4:0]  read_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      read_data,
    output logic             frame_accepted,
    output logic [7:0]       card_type,
    output logic             data_cleared,
    output logic             led_one,
    output logic             led_two,
    output logic             beep_on,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CMP_W-1:0] BUF_X = CMP_W'(BUFFER_BYTES);

    logic [CW-1:0]  byte_count_reg, byte_count_next;
    logic [7:0]     running_xor_reg, running_xor_next;
    logic           tail_ok_reg, tail_ok_next;
    logic [7:0]     byte_reg [KEEP_BYTES];
    logic [7:0]     byte_next [KEEP_BYTES];
    logic [15:0]    common_reg [WORDS];
    logic [15:0]    common_next [WORDS];
    logic [15:0]    low_reg [WORDS];
    logic [15:0]    low_next [WORDS];
    logic [15:0]    high_reg [WORDS];
    logic [15:0]    high_next [WORDS];
    logic           hold_active_reg, hold_active_next;
    logic [15:0]    hold_rem_reg, hold_rem_next;
    logic [15:0]    beep_rem_reg, beep_rem_next;
    logic           led_one_reg, led_one_next;
    logic           led_two_reg, led_two_next;
    logic [15:0]    hold_ticks_reg;
    logic [15:0]    beep_ticks_reg;

    result_t        res;
    result_t        out_reg;
    result_t        skid_reg;
    logic           out_valid_reg;
    logic           skid_valid_reg;
    logic           in_acc;

    logic [7:0]       len;
    logic [7:0]       xor_len;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] len_x;
    logic [7:0]       fb [KEEP_BYTES];
    logic             frame_ok;
    logic [4:0]       ri_off;

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && in_ready;

    assign len   = byte_reg[1];
    assign cnt_x = {{(CMP_W - CW){1'b0}}, byte_count_reg};
    assign len_x = {1'b0, len};

    always_comb
    begin
        for (int k = 0; k < KEEP_BYTES; k++)
        begin
            fb[k] = (8'(k) < len) ? byte_reg[k] : 8'h00;
        end
    end

    assign frame_ok = (cnt_x >= CMP_W'(2)) && (byte_reg[0] == FRAME_HEAD)
                      && (len >= MIN_LEN) && (len_x <= BUF_X) && (cnt_x >= len_x)
                      && (running_xor_reg == 8'h00) && tail_ok_reg;

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        running_xor_next = running_xor_reg;
        tail_ok_next     = tail_ok_reg;
        byte_next        = byte_reg;
        common_next      = common_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        hold_active_next = hold_active_reg;
        hold_rem_next    = hold_rem_reg;
        beep_rem_next    = beep_rem_reg;
        led_one_next     = led_one_reg;
        led_two_next     = led_two_reg;
        res              = '0;
        xor_len          = len;
        ri_off           = 5'd0;

        case (op)
            OP_BYTE:
            begin
                if (cnt_x < BUF_X)
                begin
                    byte_count_next = byte_count_reg + 1'b1;
                    if (cnt_x < CMP_W'(KEEP_BYTES))
                    begin
                        byte_next[byte_count_reg[KEEP_IDX_W-1:0]] = rx_byte;
                    end
                    xor_len = (cnt_x == CMP_W'(1)) ? rx_byte : len;
                    if ((cnt_x >= CMP_W'(1)) && (cnt_x + CMP_W'(2) <= {1'b0, xor_len}))
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                    end
                    if ((cnt_x >= CMP_W'(2)) && (cnt_x + CMP_W'(1) == len_x))
                    begin
                        tail_ok_next = (rx_byte == FRAME_TAIL);
                    end
                end
            end
            OP_END:
            begin
                if (frame_ok)
                begin
                    res.frame_accepted = 1'b1;
                    res.card_type      = byte_reg[2];
                    hold_active_next   = 1'b1;
                    hold_rem_next      = hold_ticks_reg;
                    beep_rem_next      = beep_ticks_reg;
                    if (byte_reg[2] == TYPE_LOW)
                    begin
                        low_next[0]    = TAG_ONE;
                        low_next[1]    = {8'h00, fb[5]};
                        low_next[2]    = {fb[6], fb[7]};
                        low_next[3]    = {fb[8], fb[9]};
                        common_next[0] = TAG_ONE;
                        common_next[1] = {8'h00, fb[5]};
                        common_next[2] = {fb[6], fb[7]};
                        common_next[3] = {fb[8], fb[9]};
                        led_one_next   = 1'b1;
                        led_two_next   = 1'b0;
                    end
                    else if ((byte_reg[2] == TYPE_HIGH_A) || (byte_reg[2] == TYPE_HIGH_B))
                    begin
                        high_next[0]   = TAG_ONE;
                        high_next[1]   = 16'h0000;
                        high_next[2]   = {fb[5], fb[6]};
                        high_next[3]   = {fb[7], fb[8]};
                        common_next[0] = TAG_TWO;
                        common_next[1] = 16'h0000;
                        common_next[2] = {fb[5], fb[6]};
                        common_next[3] = {fb[7], fb[8]};
                        led_two_next   = 1'b1;
                    end
                    else if (is_common_type(byte_reg[2]))
                    begin
                        common_next[0] = {8'h00, byte_reg[2]};
                        common_next[2] = {fb[4], fb[5]};
                        common_next[3] = {fb[6], fb[7]};
                    end
                end
                byte_count_next  = '0;
                running_xor_next = 8'h00;
                tail_ok_next     = 1'b0;
            end
            OP_TICK:
            begin
                if (beep_rem_reg != 16'h0000)
                begin
                    beep_rem_next = beep_rem_reg - 16'd1;
                end
                if (hold_active_reg)
                begin
                    if (hold_rem_reg <= 16'd1)
                    begin
                        hold_rem_next    = 16'h0000;
                        hold_active_next = 1'b0;
                        for (int w = 0; w < WORDS; w++)
                        begin
                            common_next[w] = 16'h0000;
                            low_next[w]    = 16'h0000;
                            high_next[w]   = 16'h0000;
                        end
                        led_one_next      = 1'b0;
                        led_two_next      = 1'b0;
                        res.data_cleared  = 1'b1;
                    end
                    else
                    begin
                        hold_rem_next = hold_rem_reg - 16'd1;
                    end
                end
            end
            OP_READ:
            begin
                if (read_index < 5'(WORDS))
                begin
                    res.read_data = common_reg[read_index[1:0]];
                end
                else if ((read_index >= LOW_BASE) && (read_index < HIGH_BASE))
                begin
                    ri_off        = read_index - LOW_BASE;
                    res.read_data = low_reg[ri_off[1:0]];
                end
                else if ((read_index >= HIGH_BASE) && (read_index < HIGH_END))
                begin
                    ri_off        = read_index - HIGH_BASE;
                    res.read_data = high_reg[ri_off[1:0]];
                end
            end
            default:
            begin
                res = '0;
            end
        endcase

        res.led_one = led_one_next;
        res.led_two = led_two_next;
        res.beep_on = (beep_rem_next != 16'h0000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            running_xor_reg <= 8'h00;
            tail_ok_reg     <= 1'b0;
            hold_active_reg <= 1'b0;
            hold_rem_reg    <= 16'h0000;
            beep_rem_reg    <= 16'h0000;
            led_one_reg     <= 1'b0;
            led_two_reg     <= 1'b0;
            for (int w = 0; w < WORDS; w++)
            begin
                common_reg[w] <= 16'h0000;
                low_reg[w]    <= 16'h0000;
                high_reg[w]   <= 16'h0000;
            end
        end
        else if (in_acc)
        begin
            byte_count_reg  <= byte_count_next;
            running_xor_reg <= running_xor_next;
            tail_ok_reg     <= tail_ok_next;
            hold_active_reg <= hold_active_next;
            hold_rem_reg    <= hold_rem_next;
            beep_rem_reg    <= beep_rem_next;
            led_one_reg     <= led_one_next;
            led_two_reg     <= led_two_next;
            common_reg      <= common_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            byte_reg <= byte_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_RESET;
            beep_ticks_reg <= BEEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD: hold_ticks_reg <= cfg_data;
                CFG_BEEP: beep_ticks_reg <= cfg_data;
                default:  hold_ticks_reg <= hold_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_acc)
            begin
                out_reg <= res;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = out_reg.read_data;
    assign frame_accepted = out_reg.frame_accepted;
    assign card_type      = out_reg.card_type;
    assign data_cleared   = out_reg.data_cleared;
    assign led_one        = out_reg.led_one;
    assign led_two        = out_reg.led_two;
    assign beep_on        = out_reg.beep_on;

endmodule

`default_nettype wire

### hdl/cfrh_checker.sv
// Port-level checker for the card frame receiver with hold timer, bound to the top level.
// Depends on cfrh_pkg for the frame type codes.
`default_nettype none

module cfrh_checker
    import cfrh_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] read_data,
    input wire logic        frame_accepted,
    input wire logic [7:0]  card_type,
    input wire logic        data_cleared,
    input wire logic        led_one,
    input wire logic        led_two
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
        && $stable(frame_accepted) && $stable(card_type) && $stable(data_cleared))
        else $error("result changed while stalled");

    a_type_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_accepted |-> card_type == 8'h00)
        else $error("card type shown without an accepted frame");

    a_clear_turns_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_cleared |-> !led_one && !led_two && read_data == 16'h0000
        && !frame_accepted)
        else $error("clearing transaction left indicators on or carried other results");

    a_low_type_leds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_accepted && card_type == TYPE_LOW |-> led_one && !led_two)
        else $error("low-frequency frame did not set indicators");

    a_high_type_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_accepted && (card_type == TYPE_HIGH_A || card_type == TYPE_HIGH_B)
        |-> led_two && read_data == 16'h0000)
        else $error("high-frequency frame did not set its indicator");

endmodule

bind card_frame_receiver_with_hold cfrh_checker u_cfrh_checker (.*);

`default_nettype wire
